// ===== hw/rtl/svs_pkg.sv =====
// ----------------------------------------------------------------------------
// svs_pkg
// Shared types, codes and helpers of the weighted vertex skinning block.
// ----------------------------------------------------------------------------
package svs_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_FIN,
    S_OUT
  } state_t;

  // kind of accumulation group
  typedef enum logic [2:0] {
    K_MAT,
    K_SP,
    K_SN,
    K_PB,
    K_NB
  } kind_t;

  // action codes
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_WEIGHT = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // quaternion component selects
  localparam logic [1:0] Q_W = 2'd0;
  localparam logic [1:0] Q_X = 2'd1;
  localparam logic [1:0] Q_Y = 2'd2;
  localparam logic [1:0] Q_Z = 2'd3;

  // group sequence: nine matrix entries, then four groups per row
  localparam logic [4:0] GRP_MAT_N = 5'd9;
  localparam logic [4:0] GRP_LAST  = 5'd20;

  // 1.0 at scale 2^-28
  localparam logic signed [67:0] ONE_Q28 = 68'sd268435456;

  // one joint table entry
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
  } joint_t;

  // one product term of a rotation matrix entry, taken twice
  typedef struct packed {
    logic [1:0] sel_a;
    logic [1:0] sel_b;
    logic       neg;
  } qterm_t;

  // terms of M = I + 2w[u]x + 2(u u^T - |u|^2 I), row-major entry e
  function automatic qterm_t mat_term(input logic [3:0] e, input logic t);
    qterm_t r;
    case ({e, t})
      5'd0:    r = '{sel_a: Q_Y, sel_b: Q_Y, neg: 1'b1};
      5'd1:    r = '{sel_a: Q_Z, sel_b: Q_Z, neg: 1'b1};
      5'd2:    r = '{sel_a: Q_X, sel_b: Q_Y, neg: 1'b0};
      5'd3:    r = '{sel_a: Q_W, sel_b: Q_Z, neg: 1'b1};
      5'd4:    r = '{sel_a: Q_X, sel_b: Q_Z, neg: 1'b0};
      5'd5:    r = '{sel_a: Q_W, sel_b: Q_Y, neg: 1'b0};
      5'd6:    r = '{sel_a: Q_X, sel_b: Q_Y, neg: 1'b0};
      5'd7:    r = '{sel_a: Q_W, sel_b: Q_Z, neg: 1'b0};
      5'd8:    r = '{sel_a: Q_X, sel_b: Q_X, neg: 1'b1};
      5'd9:    r = '{sel_a: Q_Z, sel_b: Q_Z, neg: 1'b1};
      5'd10:   r = '{sel_a: Q_Y, sel_b: Q_Z, neg: 1'b0};
      5'd11:   r = '{sel_a: Q_W, sel_b: Q_X, neg: 1'b1};
      5'd12:   r = '{sel_a: Q_X, sel_b: Q_Z, neg: 1'b0};
      5'd13:   r = '{sel_a: Q_W, sel_b: Q_Y, neg: 1'b1};
      5'd14:   r = '{sel_a: Q_Y, sel_b: Q_Z, neg: 1'b0};
      5'd15:   r = '{sel_a: Q_W, sel_b: Q_X, neg: 1'b0};
      5'd16:   r = '{sel_a: Q_X, sel_b: Q_X, neg: 1'b1};
      5'd17:   r = '{sel_a: Q_Y, sel_b: Q_Y, neg: 1'b1};
      default: r = '{sel_a: Q_W, sel_b: Q_W, neg: 1'b0};
    endcase
    return r;
  endfunction

  // diagonal entries start from 1.0
  function automatic logic mat_diag(input logic [3:0] e);
    return (e == 4'd0) || (e == 4'd4) || (e == 4'd8);
  endfunction

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [68:0] v);
    logic signed [31:0] r;
    if (v > 69'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -69'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/skeletal_vertex_skinning.sv =====
// ----------------------------------------------------------------------------
// skeletal_vertex_skinning
// Weighted skinning of vertex positions and normals against a joint table,
// built around one shared 33x33 multiplier and accumulator.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid/in_ready) carries words of three kinds.
// A load word writes one joint (position, orientation) into the joint table;
// a start word stores the vertex normal and clears both sums; a weight word
// rotates its offset and the normal by the joint's quaternion, scales by the
// bias and adds into the sums. A start or weight word with last_weight set
// makes one result word on out_valid/out_ready with the six sums.
// A weight word occupies the block while the shared multiplier forms the 18
// quaternion products of the rotation matrix, then per row 3+3 matrix
// products and 4 bias products, each in a multiply state and an
// accumulate state, with one finish state per group of products. in_ready
// is low during that time.
// A result is held on the out_ ports until taken; in_ready stays low while
// it waits, so a stalled receiver stalls the input.
// Reset clears the sequencer, the stored normal and the sums; the joint
// table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module skeletal_vertex_skinning
  import svs_pkg::*;
#(
  parameter int JOINT_COUNT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [5:0]         in_joint_index,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic [16:0]        in_bias,
  input  logic               in_last_weight,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_norm_x,
  output logic signed [31:0] out_norm_y,
  output logic signed [31:0] out_norm_z
);

  localparam int AW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

  localparam logic [1:0] SH_NONE = 2'd0;
  localparam logic [1:0] SH_ONE  = 2'd1;
  localparam logic [1:0] SH_WORD = 2'd2;

  state_t state_r, state_nxt;

  logic              acc_in;
  logic [AW+5:0]     idx_ext;
  logic [AW-1:0]     addr;
  logic              in_rng;

  joint_t            jt_mem [JOINT_COUNT];
  joint_t            mem_q_r;
  logic              range_r;

  logic signed [31:0] vec_r  [3];
  logic signed [15:0] nrm_r  [3];
  logic [16:0]        bias_r;
  logic               last_r;

  logic signed [31:0] pos_sum_r  [3];
  logic signed [31:0] norm_sum_r [3];

  logic [4:0]         grp_r;
  logic [1:0]         trm_r;

  logic signed [30:0] m_r [9];
  logic signed [37:0] p_r;
  logic signed [48:0] sn_r;

  logic signed [65:0] prod_r;
  logic [1:0]         sh_r;
  logic               neg_r;
  logic signed [67:0] acc_r;

  // group decode
  kind_t              kind;
  logic [1:0]         row;
  logic [3:0]         ent;
  logic [4:0]         gk;
  logic [1:0]         nterm;
  logic               last_trm;
  logic [3:0]         mi;

  // operand selection
  logic signed [15:0] qv [4];
  logic signed [31:0] jp [3];
  qterm_t             qt;
  logic signed [32:0] op_a, op_b;
  logic [1:0]         sh_sel;
  logic               neg_sel;

  // accumulate and finish
  logic signed [67:0] term;
  logic signed [67:0] acc_base;
  logic signed [67:0] r4, r16, r24, r38;
  logic signed [68:0] pos_add, norm_add;

  assign acc_in  = in_valid && in_ready;
  assign idx_ext = {{AW{1'b0}}, in_joint_index};
  assign addr    = idx_ext[AW-1:0];
  assign in_rng  = idx_ext < (AW+6)'(JOINT_COUNT);

  // joint table
  always_ff @(posedge clk) begin
    if (acc_in && (in_action == ACT_LOAD) && in_rng) begin
      jt_mem[addr] <= '{px: in_vec_x, py: in_vec_y, pz: in_vec_z,
                        qw: in_quat_w, qx: in_quat_x, qy: in_quat_y, qz: in_quat_z};
    end
    if (acc_in && (in_action == ACT_WEIGHT)) begin
      mem_q_r <= jt_mem[addr];
    end
  end

  // weight word capture
  always_ff @(posedge clk) begin
    if (acc_in && (in_action == ACT_WEIGHT)) begin
      range_r  <= in_rng;
      vec_r[0] <= in_vec_x;
      vec_r[1] <= in_vec_y;
      vec_r[2] <= in_vec_z;
      bias_r   <= in_bias;
    end
    if (acc_in) begin
      last_r <= in_last_weight;
    end
  end

  // group decode
  always_comb begin
    gk    = grp_r - GRP_MAT_N;
    kind  = K_MAT;
    row   = 2'd0;
    ent   = grp_r[3:0];
    nterm = 2'd2;
    if (grp_r >= GRP_MAT_N) begin
      row = gk[3:2];
      case (gk[1:0])
        2'd0:    kind = K_SP;
        2'd1:    kind = K_SN;
        2'd2:    kind = K_PB;
        default: kind = K_NB;
      endcase
      if ((gk[1:0] == 2'd0) || (gk[1:0] == 2'd1)) begin
        nterm = 2'd3;
      end
    end
    last_trm = (trm_r == nterm - 2'd1);
    mi       = {row, 1'b0} + {2'b00, row} + {2'b00, trm_r};
  end

  // joint values, zero for an index beyond the table
  always_comb begin
    qv[0] = range_r ? mem_q_r.qw : '0;
    qv[1] = range_r ? mem_q_r.qx : '0;
    qv[2] = range_r ? mem_q_r.qy : '0;
    qv[3] = range_r ? mem_q_r.qz : '0;
    jp[0] = range_r ? mem_q_r.px : '0;
    jp[1] = range_r ? mem_q_r.py : '0;
    jp[2] = range_r ? mem_q_r.pz : '0;
  end

  // multiplier operand mux
  always_comb begin
    qt      = mat_term(ent, trm_r[0]);
    op_a    = '0;
    op_b    = '0;
    sh_sel  = SH_NONE;
    neg_sel = 1'b0;
    case (kind)
      K_MAT: begin
        op_a    = {{17{qv[qt.sel_a][15]}}, qv[qt.sel_a]};
        op_b    = {{17{qv[qt.sel_b][15]}}, qv[qt.sel_b]};
        sh_sel  = SH_ONE;
        neg_sel = qt.neg;
      end
      K_SP: begin
        op_a = {{2{m_r[mi][30]}}, m_r[mi]};
        op_b = {vec_r[trm_r][31], vec_r[trm_r]};
      end
      K_SN: begin
        op_a = {{2{m_r[mi][30]}}, m_r[mi]};
        op_b = {{17{nrm_r[trm_r][15]}}, nrm_r[trm_r]};
      end
      K_PB: begin
        op_b = {16'b0, bias_r};
        if (trm_r == 2'd0) begin
          op_a = {1'b0, p_r[31:0]};
        end else begin
          op_a   = {{27{p_r[37]}}, p_r[37:32]};
          sh_sel = SH_WORD;
        end
      end
      default: begin
        op_b = {16'b0, bias_r};
        if (trm_r == 2'd0) begin
          op_a = {1'b0, sn_r[31:0]};
        end else begin
          op_a   = {{16{sn_r[48]}}, sn_r[48:32]};
          sh_sel = SH_WORD;
        end
      end
    endcase
  end

  // shifted product and rounded group results
  always_comb begin
    case (sh_r)
      SH_ONE:  term = {{2{prod_r[65]}}, prod_r} <<< 1;
      SH_WORD: term = {{2{prod_r[65]}}, prod_r} <<< 32;
      default: term = {{2{prod_r[65]}}, prod_r};
    endcase
    acc_base = ((kind == K_MAT) && mat_diag(ent)) ? ONE_Q28 : '0;
    r4       = (acc_r + 68'sd8) >>> 4;
    r16      = (acc_r + 68'sd32768) >>> 16;
    r24      = (acc_r + 68'sd8388608) >>> 24;
    r38      = (acc_r + 68'sd137438953472) >>> 38;
    pos_add  = {{37{pos_sum_r[row][31]}}, pos_sum_r[row]} + {r16[67], r16};
    norm_add = {{37{norm_sum_r[row][31]}}, norm_sum_r[row]} + {r38[67], r38};
  end

  // shared multiplier and accumulator
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      prod_r <= op_a * op_b;
      sh_r   <= sh_sel;
      neg_r  <= neg_sel;
    end
    if (state_r == S_ADD) begin
      if (trm_r == 2'd0) begin
        acc_r <= neg_r ? (acc_base - term) : (acc_base + term);
      end else begin
        acc_r <= neg_r ? (acc_r - term) : (acc_r + term);
      end
    end
  end

  // group results
  always_ff @(posedge clk) begin
    if (state_r == S_FIN) begin
      case (kind)
        K_MAT:   m_r[ent] <= r4[30:0];
        K_SP:    p_r <= {{6{jp[row][31]}}, jp[row]} + r24[37:0];
        K_SN:    sn_r <= acc_r[48:0];
        default: ;
      endcase
    end
  end

  // normal and sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        nrm_r[i]      <= '0;
        pos_sum_r[i]  <= '0;
        norm_sum_r[i] <= '0;
      end
    end else if (acc_in && (in_action == ACT_START)) begin
      nrm_r[0] <= in_vec_x[15:0];
      nrm_r[1] <= in_vec_y[15:0];
      nrm_r[2] <= in_vec_z[15:0];
      for (int i = 0; i < 3; i++) begin
        pos_sum_r[i]  <= '0;
        norm_sum_r[i] <= '0;
      end
    end else if (state_r == S_FIN) begin
      if (kind == K_PB) begin
        pos_sum_r[row] <= sat32(pos_add);
      end else if (kind == K_NB) begin
        norm_sum_r[row] <= sat32(norm_add);
      end
    end
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      grp_r   <= '0;
      trm_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (acc_in) begin
        grp_r <= '0;
        trm_r <= '0;
      end else if ((state_r == S_ADD) && !last_trm) begin
        trm_r <= trm_r + 2'd1;
      end else if (state_r == S_FIN) begin
        trm_r <= '0;
        grp_r <= grp_r + 5'd1;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          if (in_action == ACT_WEIGHT) begin
            state_nxt = S_MUL;
          end else if ((in_action == ACT_START) && in_last_weight) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_MUL: state_nxt = S_ADD;
      S_ADD: state_nxt = last_trm ? S_FIN : S_MUL;
      S_FIN: begin
        if (grp_r == GRP_LAST) begin
          state_nxt = last_r ? S_OUT : S_IDLE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_pos_x  = pos_sum_r[0];
  assign out_pos_y  = pos_sum_r[1];
  assign out_pos_z  = pos_sum_r[2];
  assign out_norm_x = norm_sum_r[0];
  assign out_norm_y = norm_sum_r[1];
  assign out_norm_z = norm_sum_r[2];

`ifndef SYNTH
  // a weight word starts the sequence at its first product
  a_weight_start: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && (in_action == ACT_WEIGHT)) |=>
      ((state_r == S_MUL) && (grp_r == 5'd0) && (trm_r == 2'd0)))
    else $error("weight word did not start the sequence");

  // term counter stays inside its group
  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD) |-> (trm_r < nterm))
    else $error("term index past group length");

  // group counter never runs past the last group
  a_group_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_OUT) |-> (grp_r <= GRP_LAST))
    else $error("group index past last group");

  // a weight without the flag returns to idle with no result
  a_no_flag_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && (grp_r == GRP_LAST) && !last_r) |=> (state_r == S_IDLE))
    else $error("result raised without last weight");
`endif

endmodule

// ===== bench/skeletal_vertex_skinning_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skeletal_vertex_skinning_test
// Self-checking bench: joint loads, vertex starts and weights go in under
// random idling; each result word is checked field by field against an
// in-bench fixed-point skinning predictor.
// ----------------------------------------------------------------------------
module skeletal_vertex_skinning_test
  import svs_pkg::*;
();

  localparam int NJ = 64;
  localparam longint CYCLE_LIMIT = 64'd3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_action = ACT_LOAD;
  logic [5:0] in_joint_index = '0;
  logic signed [31:0] in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic signed [15:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic [16:0] in_bias = '0;
  logic in_last_weight = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_norm_x, out_norm_y, out_norm_z;

  typedef struct {
    logic signed [31:0] p[3];
    logic signed [31:0] n[3];
  } skin_t;

  skin_t skin_q[$];
  longint cycles = 0;
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;

  // predictor state
  logic signed [31:0] jpos[NJ][3];
  logic signed [15:0] jq[NJ][4];
  bit loaded[NJ];
  logic signed [15:0] vnorm[3];
  logic signed [31:0] psum[3];
  logic signed [31:0] nsum[3];

  skeletal_vertex_skinning uut (.*);

  always #10 clk = ~clk;

  // round half up at 2^-s
  function automatic longint rnd(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [127:0] rnd_wide(logic signed [127:0] v, int s);
    return (v + (128'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp_add(logic signed [31:0] a, longint b);
    longint r;
    r = longint'(a) + b;
    if (r > 64'sd2147483647) return 32'sh7fffffff;
    if (r < -64'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

  // skinning predictor: returns 1 when the word makes a result
  function automatic bit skin_word(logic [1:0] act, logic [5:0] idx,
                                   logic signed [31:0] vx, vy, vz,
                                   logic signed [15:0] qw, qx, qy, qz,
                                   logic [16:0] bias, logic last, output skin_t r);
    longint w, x, y, z, v[3], m[3][3], sp, sn, pt;
    longint sn_b;
    logic signed [127:0] big;
    w = 0; x = 0; y = 0; z = 0;
    v[0] = vx; v[1] = vy; v[2] = vz;
    if (act == ACT_LOAD) begin
      jpos[idx][0] = vx; jpos[idx][1] = vy; jpos[idx][2] = vz;
      jq[idx][0] = qw; jq[idx][1] = qx; jq[idx][2] = qy; jq[idx][3] = qz;
      loaded[idx] = 1;
      return 0;
    end
    if (act == ACT_START) begin
      vnorm[0] = vx[15:0]; vnorm[1] = vy[15:0]; vnorm[2] = vz[15:0];
      for (int i = 0; i < 3; i++) begin psum[i] = 0; nsum[i] = 0; end
    end else if (act == ACT_WEIGHT) begin
      w = jq[idx][0]; x = jq[idx][1]; y = jq[idx][2]; z = jq[idx][3];
      m[0][0] = (64'sd1 <<< 28) - 2 * (y * y + z * z);
      m[0][1] = 2 * (x * y - w * z);
      m[0][2] = 2 * (x * z + w * y);
      m[1][0] = 2 * (x * y + w * z);
      m[1][1] = (64'sd1 <<< 28) - 2 * (x * x + z * z);
      m[1][2] = 2 * (y * z - w * x);
      m[2][0] = 2 * (x * z - w * y);
      m[2][1] = 2 * (y * z + w * x);
      m[2][2] = (64'sd1 <<< 28) - 2 * (x * x + y * y);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) m[i][j] = rnd(m[i][j], 4);
      for (int i = 0; i < 3; i++) begin
        sp = 0; sn = 0;
        for (int j = 0; j < 3; j++) begin
          sp += m[i][j] * v[j];
          sn += m[i][j] * longint'(vnorm[j]);
        end
        pt = longint'(jpos[idx][i]) + rnd(sp, 24);
        big = 128'(signed'(pt)) * 128'(signed'({1'b0, bias}));
        psum[i] = clamp_add(psum[i], 64'(rnd_wide(big, 16)));
        big = 128'(signed'(sn)) * 128'(signed'({1'b0, bias}));
        sn_b = 64'(rnd_wide(big, 38));
        nsum[i] = clamp_add(nsum[i], sn_b);
      end
    end else begin
      return 0;
    end
    if (!last) return 0;
    for (int i = 0; i < 3; i++) begin r.p[i] = psum[i]; r.n[i] = nsum[i]; end
    return 1;
  endfunction

  // cycle limit and receiver stalls
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // result checker
  always @(posedge clk) begin
    skin_t e;
    logic signed [31:0] got[6];
    if (rst_n && out_valid && out_ready) begin
      got = '{out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z};
      if (skin_q.size() == 0) begin
        $display("%0t unexpected word: pos %0d %0d %0d", $time, got[0], got[1], got[2]);
        errors++;
      end else begin
        e = skin_q.pop_front();
        for (int i = 0; i < 6; i++)
          if ((i < 3 ? e.p[i] : e.n[i - 3]) !== got[i]) begin
            $display("%0t field %0d: expected %0d actual %0d", $time, i,
                     (i < 3 ? e.p[i] : e.n[i - 3]), got[i]);
            errors++;
          end
      end
    end
  end

  // send one word, predict at acceptance; valid stays up until the next
  // call either idles or drives a new word
  task automatic send_word(logic [1:0] act, logic [5:0] idx,
                           logic signed [31:0] vx, vy, vz,
                           logic signed [15:0] qw, qx, qy, qz,
                           logic [16:0] bias, logic last);
    skin_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; in_action <= act; in_joint_index <= idx;
    in_vec_x <= vx; in_vec_y <= vy; in_vec_z <= vz;
    in_quat_w <= qw; in_quat_x <= qx; in_quat_y <= qy; in_quat_z <= qz;
    in_bias <= bias; in_last_weight <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (skin_word(act, idx, vx, vy, vz, qw, qx, qy, qz, bias, last, r))
      skin_q.push_back(r);
  endtask

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      default: return $signed($urandom_range(131072)) - 65536;
    endcase
  endfunction

  // random unit-ish quaternion or raw random values
  task automatic rand_quat(output logic signed [15:0] q[4]);
    if ($urandom_range(9) == 0) begin
      for (int i = 0; i < 4; i++) q[i] = 16'($urandom);
    end else begin
      for (int i = 0; i < 4; i++) q[i] = 16'($signed($urandom_range(16384)) - 8192);
    end
  endtask

  task automatic load_joint(int j);
    logic signed [15:0] q[4];
    rand_quat(q);
    send_word(ACT_LOAD, 6'(j), rand_pos(), rand_pos(), rand_pos(), q[0], q[1], q[2], q[3],
              17'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (skin_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic test_directed();
    for (int j = 0; j < NJ; j++) load_joint(j);
    // extreme joint: identity rotation, extreme position
    send_word(ACT_LOAD, 6'd63, 32'sh7fffffff, 32'sh80000000, 0, 16384, 0, 0, 0, 0, 1);
    send_word(ACT_LOAD, 6'd0, 0, 0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 0, 0);
    // empty vertex
    send_word(ACT_START, 6'd5, 32'hffff4000, 0, 32'h0000c000, 0, 0, 0, 0, 0, 1);
    // saturating weights, bias above one and full range
    send_word(ACT_START, 6'd0, 32'h00007fff, 32'hffff8000, 32'h00004000, 0, 0, 0, 0, 0, 0);
    send_word(ACT_WEIGHT, 6'd63, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0,
              17'h1ffff, 0);
    send_word(ACT_WEIGHT, 6'd63, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0,
              17'h1ffff, 1);
    // weight without start, extreme quaternion, zero and unit bias
    send_word(ACT_WEIGHT, 6'd0, -1, 1, 32'sh80000000, 0, 0, 0, 0, 17'd65536, 0);
    send_word(ACT_WEIGHT, 6'd0, 1, -1, 0, 0, 0, 0, 0, 17'd0, 1);
    // unused action ignored
    send_word(ACT_UNUSED, 6'd7, $urandom, $urandom, $urandom, 1, 1, 1, 1, 17'd12, 1);
    send_word(ACT_WEIGHT, 6'd7, 0, 0, 0, 0, 0, 0, 0, 17'd65536, 1);
  endtask

  // mostly well-formed vertices with occasional reloads and noise
  task automatic test_random(int words, int idle, int stall);
    int n;
    send_idle = idle; recv_stall = stall;
    n = 0;
    while (n < words) begin
      case ($urandom_range(19))
        0: begin load_joint($urandom_range(NJ - 1)); n++; end
        1: begin
          send_word(ACT_WEIGHT, 6'($urandom_range(NJ - 1)), rand_pos(), rand_pos(),
                    rand_pos(), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 17'($urandom), 1'($urandom_range(1)));
          n++;
        end
        2: begin
          send_word(ACT_UNUSED, 6'($urandom), $urandom, $urandom, $urandom,
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    17'($urandom), 1'($urandom_range(1)));
        end
        default: begin
          int k;
          k = $urandom_range(4);
          send_word(ACT_START, 6'($urandom), $urandom, $urandom, $urandom,
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    17'($urandom), k == 0);
          n++;
          for (int i = 0; i < k; i++) begin
            send_word(ACT_WEIGHT, 6'($urandom_range(NJ - 1)), rand_pos(), rand_pos(),
                      rand_pos(), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom),
                      ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536)),
                      i == k - 1);
            n++;
          end
        end
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(600, 0, 0);
    // sender holds off until all results are back
    drain();
    test_random(450, 74, 0);
    test_random(450, 0, 74);
    test_random(450, 25, 25);
    drain();
    if (errors == 0 && skin_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
